// ----- sv/rectab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and the name key helper for the record slot table.
// No dependencies; every other file of the block uses this package.
package rectab_pkg;

  localparam int SLOTS      = 16;
  localparam int NAME_BYTES = 3;
  localparam int NAME_W     = 8 * NAME_BYTES;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W       = 16;
  localparam int KIND_W     = 3;
  localparam int KEY_W      = 24;
  localparam int SLOT_W     = 4;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DEL_ID  = 3'd2,
    CMD_DEL_ALL = 3'd3,
    CMD_FIND    = 3'd4,
    CMD_SORT    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SORT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [ID_W-1:0]   entry_id;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  name_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   assigned_id;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    logic [NAME_W-1:0] name;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             scan_step;
    logic             sort_step;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  typedef struct packed {
    logic out_valid;
  } sts_t;

  // Characters after the first zero character do not take part in ordering.
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] key);
    logic [NAME_W-1:0] res;
    logic              stop;
    res  = '0;
    stop = 1'b0;
    for (int b = NAME_BYTES - 1; b >= 0; b--) begin
      if (key[8*b +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*b +: 8] = key[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rectab_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine of the record slot table: sequences accept, scan,
// sort and result hand-off. Depends on rectab_pkg.
module rectab_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_cmd,
  input  logic                out_ready,
  input  rectab_pkg::sts_t    sts,
  output rectab_pkg::ctl_t    ctl
);

  rectab_pkg::state_t                state_r, state_nxt;
  logic [rectab_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                              last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rectab_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    ctl.idx   = cnt_r;
    in_ready  = 1'b0;
    last      = (cnt_r == rectab_pkg::IDX_W'(rectab_pkg::SLOTS - 1));
    unique case (state_r)
      rectab_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          cnt_nxt  = '0;
          priority if (in_cmd == rectab_pkg::CMD_INSERT || in_cmd == rectab_pkg::CMD_DEL_ID ||
                       in_cmd == rectab_pkg::CMD_DEL_ALL || in_cmd == rectab_pkg::CMD_FIND) begin
            state_nxt = rectab_pkg::ST_SCAN;
          end else if (in_cmd == rectab_pkg::CMD_SORT) begin
            state_nxt = rectab_pkg::ST_SORT;
          end else begin
            state_nxt = rectab_pkg::ST_DONE;
          end
        end
      end
      rectab_pkg::ST_SCAN: begin
        ctl.scan_step = 1'b1;
        cnt_nxt       = cnt_r + rectab_pkg::IDX_W'(1);
        if (last) begin
          state_nxt = rectab_pkg::ST_DONE;
        end
      end
      rectab_pkg::ST_SORT: begin
        ctl.sort_step = 1'b1;
        cnt_nxt       = cnt_r + rectab_pkg::IDX_W'(1);
        if (last) begin
          state_nxt = rectab_pkg::ST_DONE;
        end
      end
      rectab_pkg::ST_DONE: begin
        if (!sts.out_valid || out_ready) begin
          ctl.finish = 1'b1;
          state_nxt  = rectab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rectab_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (cnt_r == '0))
    else $error("step count not cleared after accepted beat");
  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> (!sts.out_valid || out_ready))
    else $error("result loaded over an untaken beat");
  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> (state_r == rectab_pkg::ST_IDLE))
    else $error("controller not idle after result hand-off");
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rectab_pkg::ST_SCAN || state_r == rectab_pkg::ST_SORT) && last)
      |=> (state_r == rectab_pkg::ST_DONE))
    else $error("pass did not end after the last slot");
`endif

endmodule
`default_nettype wire

// ----- sv/rectab_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the record slot table: rotating slot registers, id counter,
// odd-even compare-exchange network and result register. Depends on rectab_pkg.
module rectab_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rectab_pkg::ctl_t        ctl,
  output rectab_pkg::sts_t        sts,
  input  rectab_pkg::in_item_t    in_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output rectab_pkg::out_item_t   out_data
);

  rectab_pkg::entry_t                    tab_r   [rectab_pkg::SLOTS];
  rectab_pkg::entry_t                    tab_nxt [rectab_pkg::SLOTS];
  logic [rectab_pkg::NAME_W-1:0]         key     [rectab_pkg::SLOTS];
  logic [2:0]                            cmd_r, cmd_nxt;
  logic [rectab_pkg::ID_W-1:0]           eid_r, eid_nxt;
  logic [rectab_pkg::KIND_W-1:0]         kind_r, kind_nxt;
  logic [rectab_pkg::NAME_W-1:0]         name_r, name_nxt;
  logic                                  found_r, found_nxt;
  logic [rectab_pkg::IDX_W-1:0]          hit_r, hit_nxt;
  logic [rectab_pkg::ID_W-1:0]           hit_id_r, hit_id_nxt;
  logic [rectab_pkg::ID_W-1:0]           idc_r, idc_nxt;
  logic [rectab_pkg::ID_W-1:0]           idc_inc;
  logic                                  out_valid_r, out_valid_nxt;
  rectab_pkg::out_item_t                 out_r, out_nxt;
  rectab_pkg::entry_t                    head;
  rectab_pkg::entry_t                    new_entry;
  logic                                  take;
  logic                                  wipe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rectab_pkg::SLOTS; i++) begin
        tab_r[i] <= '0;
      end
      idc_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tab_r       <= tab_nxt;
      idc_r       <= idc_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    eid_r    <= eid_nxt;
    kind_r   <= kind_nxt;
    name_r   <= name_nxt;
    hit_r    <= hit_nxt;
    hit_id_r <= hit_id_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    for (int i = 0; i < rectab_pkg::SLOTS; i++) begin
      key[i] = rectab_pkg::canon_name(tab_r[i].name);
    end
  end

  always_comb begin
    tab_nxt    = tab_r;
    cmd_nxt    = cmd_r;
    eid_nxt    = eid_r;
    kind_nxt   = kind_r;
    name_nxt   = name_r;
    found_nxt  = found_r;
    hit_nxt    = hit_r;
    hit_id_nxt = hit_id_r;
    idc_nxt    = idc_r;
    idc_inc    = idc_r + rectab_pkg::ID_W'(1);
    head       = tab_r[0];
    new_entry  = '{valid: 1'b1, id: idc_inc, kind: kind_r, name: name_r};
    take       = 1'b0;
    wipe       = 1'b0;
    if (ctl.load) begin
      cmd_nxt    = in_data.command;
      eid_nxt    = in_data.entry_id;
      kind_nxt   = in_data.kind;
      name_nxt   = rectab_pkg::NAME_W'(in_data.name_key);
      found_nxt  = 1'b0;
      hit_nxt    = '0;
      hit_id_nxt = '0;
      if (in_data.command == rectab_pkg::CMD_CLEAR) begin
        for (int i = 0; i < rectab_pkg::SLOTS; i++) begin
          tab_nxt[i].valid = 1'b0;
        end
      end
    end else if (ctl.scan_step) begin
      unique case (cmd_r)
        rectab_pkg::CMD_INSERT: begin
          take = !found_r && !head.valid;
        end
        rectab_pkg::CMD_DEL_ID: begin
          take = !found_r && head.valid && (head.id == eid_r);
          wipe = take;
        end
        rectab_pkg::CMD_FIND: begin
          take = !found_r && head.valid && (head.id == eid_r);
        end
        rectab_pkg::CMD_DEL_ALL: begin
          wipe = (head.id == eid_r);
        end
        default: begin
          take = 1'b0;
        end
      endcase
      for (int i = 0; i < rectab_pkg::SLOTS - 1; i++) begin
        tab_nxt[i] = tab_r[i+1];
      end
      if (take && cmd_r == rectab_pkg::CMD_INSERT) begin
        tab_nxt[rectab_pkg::SLOTS-1] = new_entry;
        idc_nxt                      = idc_inc;
        hit_id_nxt                   = idc_inc;
      end else if (wipe) begin
        tab_nxt[rectab_pkg::SLOTS-1] = '0;
        hit_id_nxt                   = take ? eid_r : hit_id_r;
      end else begin
        tab_nxt[rectab_pkg::SLOTS-1] = head;
        hit_id_nxt                   = take ? eid_r : hit_id_r;
      end
      if (take) begin
        found_nxt = 1'b1;
        hit_nxt   = ctl.idx;
      end
    end else if (ctl.sort_step) begin
      for (int i = 0; i < rectab_pkg::SLOTS - 1; i++) begin
        if ((i[0] == ctl.idx[0]) && (key[i] > key[i+1])) begin
          tab_nxt[i]   = tab_r[i+1];
          tab_nxt[i+1] = tab_r[i];
        end
      end
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
      unique case (cmd_r)
        rectab_pkg::CMD_INSERT: begin
          out_nxt.status = found_r ? rectab_pkg::STS_OK : rectab_pkg::STS_FULL;
        end
        rectab_pkg::CMD_DEL_ID, rectab_pkg::CMD_FIND: begin
          out_nxt.status = found_r ? rectab_pkg::STS_OK : rectab_pkg::STS_NOT_FOUND;
        end
        default: begin
          out_nxt.status = rectab_pkg::STS_OK;
        end
      endcase
      out_nxt.slot        = rectab_pkg::SLOT_W'(hit_r);
      out_nxt.assigned_id = hit_id_r;
    end
  end

  assign sts.out_valid = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule
`default_nettype wire

// ----- sv/record_slot_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the record slot table: joins the controller and the datapath.
// Depends on rectab_pkg, rectab_ctrl and rectab_dp.
//
//   channel   ports                          payload
//   input     in_valid / in_ready            in_data  (rectab_pkg::in_item_t)
//   result    out_valid / out_ready          out_data (rectab_pkg::out_item_t)
//
// Insert, both deletes and find walk the slots once, one slot per cycle, and
// sort runs one odd-even compare-exchange pass per cycle for SLOTS passes.
// Clear and unknown commands go straight to the result hand-off.
// The result register holds one beat; a stalled result holds the block in its
// final state until taken. Reset is synchronous and empties every slot.
module record_slot_table_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rectab_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rectab_pkg::out_item_t out_data
);

  rectab_pkg::ctl_t ctl;
  rectab_pkg::sts_t sts;

  rectab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.command),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rectab_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for record_slot_table_unit: directed and random command beats
// are checked against a table model that the bench keeps for itself.
// Depends on rectab_pkg and the RTL of the record slot table.
module testbench;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 80;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  rectab_pkg::in_item_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rectab_pkg::out_item_t out_data;

  rectab_pkg::in_item_t          pending_cmds[$];
  rectab_pkg::out_item_t         expected_results[$];
  rectab_pkg::entry_t            table_model[rectab_pkg::SLOTS];
  logic [rectab_pkg::ID_W-1:0]   id_seq = '0;
  int          inserts_queued = 0;
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int unsigned cycle_count = 0;

  record_slot_table_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Only the characters before the first zero character take part in ordering.
  function automatic logic [rectab_pkg::NAME_W-1:0] name_order_key(
    input logic [rectab_pkg::NAME_W-1:0] nm);
    logic [rectab_pkg::NAME_W-1:0] keep;
    keep = '1;
    for (int b = rectab_pkg::NAME_BYTES - 1; b >= 0; b--) begin
      if (nm[8*b +: 8] == 8'h00) begin
        keep = keep & ({rectab_pkg::NAME_W{1'b1}} << (8 * (b + 1)));
      end
    end
    return nm & keep;
  endfunction

  function automatic rectab_pkg::out_item_t apply_command(input rectab_pkg::in_item_t c);
    rectab_pkg::out_item_t r;
    rectab_pkg::entry_t    moving;
    int                    j;
    bit                    done;
    r = '0;
    r.status = rectab_pkg::STS_OK;
    done = 1'b0;
    case (c.command)
      rectab_pkg::CMD_CLEAR: begin
        for (int i = 0; i < rectab_pkg::SLOTS; i++) begin
          table_model[i].valid = 1'b0;
        end
      end
      rectab_pkg::CMD_INSERT: begin
        r.status = rectab_pkg::STS_FULL;
        for (int i = 0; i < rectab_pkg::SLOTS && !done; i++) begin
          if (!table_model[i].valid) begin
            id_seq = id_seq + 1'b1;
            table_model[i] = {1'b1, id_seq, c.kind, c.name_key[rectab_pkg::NAME_W-1:0]};
            r.status = rectab_pkg::STS_OK;
            r.slot = rectab_pkg::SLOT_W'(i);
            r.assigned_id = id_seq;
            done = 1'b1;
          end
        end
      end
      rectab_pkg::CMD_DEL_ID, rectab_pkg::CMD_FIND: begin
        r.status = rectab_pkg::STS_NOT_FOUND;
        for (int i = 0; i < rectab_pkg::SLOTS && !done; i++) begin
          if (table_model[i].valid && table_model[i].id == c.entry_id) begin
            r.status = rectab_pkg::STS_OK;
            r.slot = rectab_pkg::SLOT_W'(i);
            r.assigned_id = c.entry_id;
            if (c.command == rectab_pkg::CMD_DEL_ID) begin
              table_model[i] = '0;
            end
            done = 1'b1;
          end
        end
      end
      rectab_pkg::CMD_DEL_ALL: begin
        for (int i = 0; i < rectab_pkg::SLOTS; i++) begin
          if (table_model[i].id == c.entry_id) begin
            table_model[i] = '0;
          end
        end
      end
      rectab_pkg::CMD_SORT: begin
        for (int i = 1; i < rectab_pkg::SLOTS; i++) begin
          moving = table_model[i];
          j = i - 1;
          while (j >= 0 &&
                 name_order_key(moving.name) < name_order_key(table_model[j].name)) begin
            table_model[j + 1] = table_model[j];
            j--;
          end
          table_model[j + 1] = moving;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : drive_proc
    bit                   offer;
    rectab_pkg::in_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_command(in_data));
      end
      if (!in_valid || in_ready) begin
        offer = (pending_cmds.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (offer) begin
          nxt = pending_cmds.pop_front();
          in_data <= nxt;
        end
        in_valid <= offer;
      end
    end
  end

  always @(posedge clk) begin : watch_proc
    rectab_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_error("result beat arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            flag_error($sformatf("status got %0d want %0d", out_data.status, want.status));
          end
          if (out_data.slot !== want.slot) begin
            flag_error($sformatf("slot got %0d want %0d", out_data.slot, want.slot));
          end
          if (out_data.assigned_id !== want.assigned_id) begin
            flag_error($sformatf("assigned_id got %0d want %0d",
                                 out_data.assigned_id, want.assigned_id));
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [rectab_pkg::KEY_W-1:0] random_name();
    logic [rectab_pkg::KEY_W-1:0] nm;
    int                           roll;
    for (int b = 0; b < 3; b++) begin
      roll = $urandom_range(9);
      if (roll < 2) nm[8*b +: 8] = 8'h00;
      else if (roll < 4) nm[8*b +: 8] = 8'h41;
      else if (roll < 6) nm[8*b +: 8] = 8'h42;
      else if (roll < 7) nm[8*b +: 8] = 8'h43;
      else if (roll < 8) nm[8*b +: 8] = 8'hFF;
      else nm[8*b +: 8] = 8'($urandom);
    end
    return nm;
  endfunction

  task automatic push_cmd(input logic [2:0] c, input logic [rectab_pkg::ID_W-1:0] eid,
                          input logic [rectab_pkg::KIND_W-1:0] k,
                          input logic [rectab_pkg::KEY_W-1:0] nm);
    rectab_pkg::in_item_t item;
    item = {c, eid, k, nm};
    pending_cmds.push_back(item);
    if (c == rectab_pkg::CMD_INSERT) begin
      inserts_queued++;
    end
  endtask

  task automatic queue_random(input int count);
    int                            roll;
    logic [2:0]                    c;
    logic [rectab_pkg::ID_W-1:0]   eid;
    logic [rectab_pkg::KIND_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 36) c = rectab_pkg::CMD_INSERT;
      else if (roll < 52) c = rectab_pkg::CMD_DEL_ID;
      else if (roll < 59) c = rectab_pkg::CMD_DEL_ALL;
      else if (roll < 80) c = rectab_pkg::CMD_FIND;
      else if (roll < 91) c = rectab_pkg::CMD_SORT;
      else if (roll < 95) c = rectab_pkg::CMD_CLEAR;
      else if (roll < 97) c = CMD_SPARE_6;
      else c = CMD_SPARE_7;
      roll = $urandom_range(99);
      if (roll < 65) begin
        eid = rectab_pkg::ID_W'(inserts_queued - int'($urandom_range(20)));
      end else if (roll < 90) begin
        eid = rectab_pkg::ID_W'($urandom_range(40));
      end else begin
        eid = rectab_pkg::ID_W'($urandom);
      end
      if ($urandom_range(99) < 85) k = rectab_pkg::KIND_W'($urandom_range(4, 1));
      else k = rectab_pkg::KIND_W'($urandom_range(7, 0));
      push_cmd(c, eid, k, random_name());
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    for (int k = 0; k < rectab_pkg::SLOTS; k++) begin
      table_model[k] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats: field extremes, a zero inside a name, misses, a full table,
    // unknown commands and a delete-all that hits an emptied slot.
    push_cmd(rectab_pkg::CMD_INSERT, 16'h0000, 3'd0, 24'h000000);
    push_cmd(rectab_pkg::CMD_INSERT, 16'hFFFF, 3'd7, 24'hFFFFFF);
    push_cmd(rectab_pkg::CMD_INSERT, 16'h0000, 3'd1, 24'h410042);
    push_cmd(rectab_pkg::CMD_INSERT, 16'h0000, 3'd4, 24'h41FF00);
    push_cmd(rectab_pkg::CMD_FIND, 16'd1, 3'd0, 24'h000000);
    push_cmd(rectab_pkg::CMD_FIND, 16'hFFFF, 3'd0, 24'h000000);
    push_cmd(rectab_pkg::CMD_DEL_ID, 16'd2, 3'd0, 24'h000000);
    push_cmd(rectab_pkg::CMD_DEL_ID, 16'd2, 3'd0, 24'h000000);
    for (int n = 0; n < 13; n++) begin
      push_cmd(rectab_pkg::CMD_INSERT, 16'h0000,
               rectab_pkg::KIND_W'($urandom_range(4, 1)), random_name());
    end
    push_cmd(rectab_pkg::CMD_INSERT, 16'h0000, 3'd2, 24'h434241);
    push_cmd(rectab_pkg::CMD_SORT, 16'h0000, 3'd0, 24'h000000);
    push_cmd(rectab_pkg::CMD_FIND, 16'd10, 3'd0, 24'h000000);
    push_cmd(CMD_SPARE_6, 16'd5, 3'd1, 24'h414141);
    push_cmd(CMD_SPARE_7, 16'd6, 3'd1, 24'h414141);
    push_cmd(rectab_pkg::CMD_CLEAR, 16'h0000, 3'd0, 24'h000000);
    push_cmd(rectab_pkg::CMD_DEL_ALL, 16'd1, 3'd0, 24'h000000);
    push_cmd(rectab_pkg::CMD_FIND, 16'd3, 3'd0, 24'h000000);
    push_cmd(rectab_pkg::CMD_INSERT, 16'h0000, 3'd3, 24'h424200);
    queue_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 58;
    recv_stall_pct = 0;
    queue_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 58;
    queue_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 27;
    recv_stall_pct = 27;
    queue_random(PHASE_ITEMS);
    wait_drained();

    // The receiver holds off while beats keep coming, so the block backs up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asked = hold_asked + 1;
    queue_random(PHASE_ITEMS);
    wait_drained();

    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
